FILE: hdl/polymorphic_inline_cache_defines.svh
// Assertion macros for the polymorphic inline cache checker.
// No dependencies; take in by `include where assertions are written.
`ifndef POLYMORPHIC_INLINE_CACHE_DEFINES_SVH
`define POLYMORPHIC_INLINE_CACHE_DEFINES_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define PIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pic assertion failed");

// Implication with antecedent and consequent in the same cycle.
`define PIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pic implication failed");

// Implication with the consequent in the next cycle.
`define PIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pic next-cycle implication failed");

`endif

FILE: hdl/pic_pkg.sv
// Shared types and constants of the polymorphic inline cache.
// No dependencies.
package pic_pkg;

  localparam int unsigned ENTRIES_DEF     = 4;
  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned SHAPE_W         = 32;
  localparam int unsigned OFF_PORT_W      = 16;
  localparam int unsigned STAT_W          = 32;
  localparam int unsigned USED_W          = 3;

  localparam logic [1:0] REQ_LOOKUP     = 2'd0;
  localparam logic [1:0] REQ_UPDATE     = 2'd1;
  localparam logic [1:0] REQ_INVALIDATE = 2'd2;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [SHAPE_W-1:0]    shape_key;
    logic [OFF_PORT_W-1:0] offset_in;
  } pic_req_t;

  typedef struct packed {
    logic                  hit;
    logic [OFF_PORT_W-1:0] offset_out;
    logic [USED_W-1:0]     entries_used;
    logic [STAT_W-1:0]     lookup_count;
    logic [STAT_W-1:0]     hit_total;
  } pic_rsp_t;

  // Control part of the request token walking the cell chain
  typedef struct packed {
    logic       active;
    logic [1:0] req;
    logic       found;
  } pic_tok_t;

endpackage

FILE: hdl/pic_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
// Payload type supplied at instantiation, normally from pic_pkg.
interface pic_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/pic_cell.sv
// One cache entry with its compare logic and one stage of the token chain.
// Depends on pic_pkg.
module pic_cell #(
  parameter int unsigned OFFSET_BITS = pic_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pic_pkg::pic_tok_t            tok_i,
  input  logic [pic_pkg::SHAPE_W-1:0]  shape_i,
  input  logic [OFFSET_BITS-1:0]       off_i,
  input  logic [OFFSET_BITS-1:0]       hit_off_i,
  output pic_pkg::pic_tok_t            tok_o,
  output logic [pic_pkg::SHAPE_W-1:0]  shape_o,
  output logic [OFFSET_BITS-1:0]       off_o,
  output logic [OFFSET_BITS-1:0]       hit_off_o,
  input  logic                         filled_i,
  input  logic                         app_wr_i,
  input  logic [pic_pkg::SHAPE_W-1:0]  app_shape_i,
  input  logic [OFFSET_BITS-1:0]       app_off_i,
  input  logic                         clr_i
);
  import pic_pkg::*;

  logic [SHAPE_W-1:0]     ent_shape_q;
  logic [OFFSET_BITS-1:0] ent_off_q;
  logic                   ent_valid_q;

  pic_tok_t               tok_q, tok_d;
  logic [SHAPE_W-1:0]     shape_q;
  logic [OFFSET_BITS-1:0] off_q, hit_off_q, hit_off_d;

  logic sel, look_hit, upd_hit;

  assign sel      = tok_i.active && !tok_i.found && filled_i && (shape_i == ent_shape_q);
  assign look_hit = sel && (tok_i.req == REQ_LOOKUP) && ent_valid_q;
  assign upd_hit  = sel && (tok_i.req == REQ_UPDATE);

  always_comb begin
    tok_d       = tok_i;
    tok_d.found = tok_i.found | look_hit | upd_hit;
    hit_off_d   = look_hit ? ent_off_q : hit_off_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= '0;
      ent_valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (clr_i) begin
        ent_valid_q <= 1'b0;
      end else if (upd_hit || app_wr_i) begin
        ent_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shape_q   <= shape_i;
    off_q     <= off_i;
    hit_off_q <= hit_off_d;
    if (upd_hit) begin
      ent_shape_q <= shape_i;
      ent_off_q   <= off_i;
    end else if (app_wr_i) begin
      ent_shape_q <= app_shape_i;
      ent_off_q   <= app_off_i;
    end
  end

  assign tok_o     = tok_q;
  assign shape_o   = shape_q;
  assign off_o     = off_q;
  assign hit_off_o = hit_off_q;

endmodule

FILE: hdl/polymorphic_inline_cache.sv
// Polymorphic inline cache top level: request stage, cell chain, finish stage.
// Depends on pic_pkg, pic_stream_if and pic_cell.
//
//   channel  dir  payload    transaction
//   req_i    in   pic_req_t  valid & ready
//   rsp_o    out  pic_rsp_t  valid & ready
//
// One request at a time: it walks the ENTRIES cells one per cycle, and the next
// can be taken once it leaves the finish stage, which waits for a free output.
// The response is registered in the output register as it leaves that stage.
// A waiting response does not block acceptance; the next one then holds in
// the finish stage until the output register drains.
// Asynchronous active-low reset empties the cache and clears the counters.
module polymorphic_inline_cache #(
  parameter int unsigned ENTRIES     = pic_pkg::ENTRIES_DEF,
  parameter int unsigned OFFSET_BITS = pic_pkg::OFFSET_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pic_stream_if.sink   req_i,
  pic_stream_if.source rsp_o
);
  import pic_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  pic_tok_t               tok_w     [ENTRIES+1];
  logic [SHAPE_W-1:0]     shape_w   [ENTRIES+1];
  logic [OFFSET_BITS-1:0] off_w     [ENTRIES+1];
  logic [OFFSET_BITS-1:0] hit_off_w [ENTRIES+1];

  logic                   busy_q;
  pic_tok_t               head_tok_q;
  logic [SHAPE_W-1:0]     head_shape_q;
  logic [OFFSET_BITS-1:0] head_off_q;

  pic_tok_t               tail_tok_q;
  logic [SHAPE_W-1:0]     tail_shape_q;
  logic [OFFSET_BITS-1:0] tail_off_q, tail_hit_off_q;

  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [STAT_W-1:0]      lookups_q, lookups_d, hits_q, hits_d;
  logic                   out_valid_q;
  pic_rsp_t               out_q;

  logic in_fire, fin, is_look, is_upd, is_inv, look_hit, app, full;

  assign in_fire     = req_i.valid && req_i.ready;
  assign req_i.ready = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_tok_q <= '0;
    end else begin
      head_tok_q.active <= in_fire;
      head_tok_q.req    <= req_i.payload.req_type;
      head_tok_q.found  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    head_shape_q <= req_i.payload.shape_key;
    head_off_q   <= OFFSET_BITS'(req_i.payload.offset_in);
  end

  assign tok_w[0]     = head_tok_q;
  assign shape_w[0]   = head_shape_q;
  assign off_w[0]     = head_off_q;
  assign hit_off_w[0] = '0;

  assign full = (fill_q == CNT_W'(ENTRIES));

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic filled, wr;
    assign filled = (CNT_W'(g) < fill_q);
    assign wr     = app && fin && (full ? (g == 0) : (CNT_W'(g) == fill_q));

    pic_cell #(
      .OFFSET_BITS (OFFSET_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok_w[g]),
      .shape_i     (shape_w[g]),
      .off_i       (off_w[g]),
      .hit_off_i   (hit_off_w[g]),
      .tok_o       (tok_w[g+1]),
      .shape_o     (shape_w[g+1]),
      .off_o       (off_w[g+1]),
      .hit_off_o   (hit_off_w[g+1]),
      .filled_i    (filled),
      .app_wr_i    (wr),
      .app_shape_i (tail_shape_q),
      .app_off_i   (tail_off_q),
      .clr_i       (fin && is_inv)
    );
  end

  assign fin      = tail_tok_q.active && (!out_valid_q || rsp_o.ready);
  assign is_look  = (tail_tok_q.req == REQ_LOOKUP);
  assign is_upd   = (tail_tok_q.req == REQ_UPDATE);
  assign is_inv   = (tail_tok_q.req == REQ_INVALIDATE);
  assign look_hit = is_look && tail_tok_q.found;
  assign app      = is_upd && !tail_tok_q.found;

  always_comb begin
    fill_d    = fill_q;
    lookups_d = lookups_q;
    hits_d    = hits_q;
    if (is_inv) begin
      fill_d = '0;
    end else if (app && !full) begin
      fill_d = CNT_W'(fill_q + 1'b1);
    end
    if (is_look && (lookups_q != '1)) begin
      lookups_d = lookups_q + 1'b1;
    end
    if (look_hit && (hits_q != '1)) begin
      hits_d = hits_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      tail_tok_q  <= '0;
      fill_q      <= '0;
      lookups_q   <= '0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (fin) begin
        busy_q <= 1'b0;
      end
      if (tok_w[ENTRIES].active) begin
        tail_tok_q <= tok_w[ENTRIES];
      end else if (fin) begin
        tail_tok_q.active <= 1'b0;
      end
      if (fin) begin
        fill_q      <= fill_d;
        lookups_q   <= lookups_d;
        hits_q      <= hits_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_w[ENTRIES].active) begin
      tail_shape_q   <= shape_w[ENTRIES];
      tail_off_q     <= off_w[ENTRIES];
      tail_hit_off_q <= hit_off_w[ENTRIES];
    end
    if (fin) begin
      out_q.hit          <= look_hit;
      out_q.offset_out   <= look_hit ? OFF_PORT_W'(tail_hit_off_q) : '0;
      out_q.entries_used <= USED_W'(fill_d);
      out_q.lookup_count <= lookups_d;
      out_q.hit_total    <= hits_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule

FILE: hdl/pic_checker.sv
// Port-level checker for the polymorphic inline cache, bound to the top level.
// Depends on pic_pkg and polymorphic_inline_cache_defines.svh.
`include "polymorphic_inline_cache_defines.svh"

module pic_checker #(
  parameter int unsigned ENTRIES = pic_pkg::ENTRIES_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic                            rsp_hit_i,
  input logic [pic_pkg::OFF_PORT_W-1:0]  rsp_offset_i,
  input logic [pic_pkg::USED_W-1:0]      rsp_used_i,
  input logic [pic_pkg::STAT_W-1:0]      rsp_lookups_i,
  input logic [pic_pkg::STAT_W-1:0]      rsp_hits_i
);
  import pic_pkg::*;

  `PIC_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `PIC_ASSERT_IMPL(a_used_max, clk_i, rst_ni, rsp_valid_i && (ENTRIES < 8), 32'(rsp_used_i) <= ENTRIES)
  `PIC_ASSERT_IMPL(a_hits_le, clk_i, rst_ni, rsp_valid_i, rsp_hits_i <= rsp_lookups_i)
  `PIC_ASSERT_IMPL(a_miss_off, clk_i, rst_ni, rsp_valid_i && !rsp_hit_i, rsp_offset_i == '0)

endmodule

bind polymorphic_inline_cache pic_checker #(
  .ENTRIES (ENTRIES)
) u_pic_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_hit_i     (rsp_o.payload.hit),
  .rsp_offset_i  (rsp_o.payload.offset_out),
  .rsp_used_i    (rsp_o.payload.entries_used),
  .rsp_lookups_i (rsp_o.payload.lookup_count),
  .rsp_hits_i    (rsp_o.payload.hit_total)
);
